/* hw/rtl/spsmr_pkg.sv */
// ----------------------------------------------------------------------------
// spsmr_pkg
// Shared types, widths and helpers for the spaced-selection revenue block.
// ----------------------------------------------------------------------------
`default_nettype none

package spsmr_pkg;

  localparam int TOTAL_W               = 32;
  localparam int REVENUE_W             = 16;
  localparam int GAP_W                 = 8;
  localparam int MILES_W               = 9;
  localparam int GAP_RESET             = 5;
  localparam int GAP_CODES             = 256;
  localparam int HISTORY_DEPTH_DEFAULT = 256;

  localparam logic [MILES_W-1:0] MILES_MAX = '1;

  // Control handed to every history cell.
  typedef struct packed {
    logic             advance;
    logic [GAP_W-1:0] slot;
  } cell_ctl_t;

  // One result beat.
  typedef struct packed {
    logic [TOTAL_W-1:0] best_total;
    logic               final_answer;
  } result_t;

  // Add with saturation at the all-ones value.
  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/spsmr_cell.sv */
// ----------------------------------------------------------------------------
// spsmr_cell
// One history cell: load the fresh total at the insert slot, else take the
// neighbor's total, on every accepted mile.
// ----------------------------------------------------------------------------
`default_nettype none

module spsmr_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire                               clk,
  input  spsmr_pkg::cell_ctl_t              ctl,
  input  wire [spsmr_pkg::TOTAL_W-1:0]      fresh,
  input  wire [spsmr_pkg::TOTAL_W-1:0]      neighbor,
  output logic [spsmr_pkg::TOTAL_W-1:0]     value
);

  logic insert_here;

  assign insert_here = (ctl.slot == spsmr_pkg::GAP_W'(CELL_INDEX));

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      value <= insert_here ? fresh : neighbor;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/spsmr_outbuf.sv */
// ----------------------------------------------------------------------------
// spsmr_outbuf
// Two-entry result buffer: output register plus skid register, so a new beat
// is taken while a finished result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module spsmr_outbuf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  spsmr_pkg::result_t   push_data,
  output logic                 full,
  input  wire                  out_stall,
  output logic                 out_valid,
  output spsmr_pkg::result_t   out_data
);

  logic               skid_valid;
  spsmr_pkg::result_t skid_data;
  logic               pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/spsmr_pkg_unused_guard.sv */
// ----------------------------------------------------------------------------
// spsmr_gapmod
// Fold the written gap into a slot of the history chain (gap modulo depth).
// ----------------------------------------------------------------------------
`default_nettype none

module spsmr_gapmod #(
  parameter int NUM_CELLS = spsmr_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  wire [spsmr_pkg::GAP_W-1:0]  gap,
  output logic [spsmr_pkg::GAP_W-1:0] slot
);

  logic [spsmr_pkg::GAP_W-1:0] mod_tab [spsmr_pkg::GAP_CODES];

  // Constant table: entry k holds k mod NUM_CELLS.
  for (genvar k = 0; k < spsmr_pkg::GAP_CODES; k++) begin : g_tab
    assign mod_tab[k] = spsmr_pkg::GAP_W'(k % NUM_CELLS);
  end

  assign slot = mod_tab[gap];

endmodule

`default_nettype wire

/* hw/rtl/spaced_selection_max_revenue_top.sv */
// ----------------------------------------------------------------------------
// spaced_selection_max_revenue_top
// Billboard placement: best revenue with chosen boards more than min_gap
// miles apart, one mile per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per mile, from mile 1, with
//   board_here, board_revenue and last_mile. A beat is taken when in_valid is
//   high and in_stall is low.
//   Output channel (out_valid / out_stall): one beat per mile with best_total
//   (saturating) and final_answer, which marks the answer for the whole road.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes min_gap; write
//   only while no mile is in flight. cfg_ready is always high.
//   Results are registered in the output buffer. Throughput: one
//   mile per cycle unless stalled. The history is a chain of cells shifting
//   one step per mile; the new total enters at cell (min_gap mod depth) and
//   leaves at cell 0 exactly min_gap+1 miles later, so no addressed read.
//   Stall: a two-entry output buffer takes a new beat while a result waits;
//   in_stall rises only once both entries hold results.
//   Reset: clears mile count, previous best and both buffer entries, sets
//   min_gap to 5. The history cells are not cleared; they are only read once
//   written in the current road. A last mile restarts the road.
// ----------------------------------------------------------------------------
`default_nettype none

module spaced_selection_max_revenue_top #(
  parameter int HISTORY_DEPTH = spsmr_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // config write
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [spsmr_pkg::GAP_W-1:0]          cfg_data,
  // mile input
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 board_here,
  input  wire [spsmr_pkg::REVENUE_W-1:0]      board_revenue,
  input  wire                                 last_mile,
  // result output
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [spsmr_pkg::TOTAL_W-1:0]       best_total,
  output logic                                final_answer
);

  // Gaps never exceed GAP_CODES-1, so cells past that would never be read.
  localparam int NUM_CELLS = (HISTORY_DEPTH < spsmr_pkg::GAP_CODES) ?
                             HISTORY_DEPTH : spsmr_pkg::GAP_CODES;

  logic [spsmr_pkg::GAP_W-1:0]   min_gap;
  logic [spsmr_pkg::GAP_W-1:0]   gap_slot;
  logic [spsmr_pkg::GAP_W-1:0]   cfg_slot;
  logic [spsmr_pkg::GAP_W-1:0]   reset_slot;
  logic [spsmr_pkg::MILES_W-1:0] miles_seen;
  logic [spsmr_pkg::TOTAL_W-1:0] prev_best;

  logic                          in_accept;
  logic                          use_earlier;
  logic [spsmr_pkg::TOTAL_W-1:0] earlier;
  logic [spsmr_pkg::TOTAL_W-1:0] take;
  logic [spsmr_pkg::TOTAL_W-1:0] best_next;

  spsmr_pkg::cell_ctl_t          cell_ctl;
  logic [spsmr_pkg::TOTAL_W-1:0] cell_val [NUM_CELLS];

  spsmr_pkg::result_t            res_in;
  spsmr_pkg::result_t            res_out;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // Fold gap to a chain slot: one table for writes, one for the reset value.
  spsmr_gapmod #(.NUM_CELLS(NUM_CELLS)) u_gapmod_cfg (
    .gap  (cfg_data),
    .slot (cfg_slot)
  );

  spsmr_gapmod #(.NUM_CELLS(NUM_CELLS)) u_gapmod_rst (
    .gap  (spsmr_pkg::GAP_W'(spsmr_pkg::GAP_RESET)),
    .slot (reset_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap  <= spsmr_pkg::GAP_W'(spsmr_pkg::GAP_RESET);
      gap_slot <= reset_slot;
    end else if (cfg_valid && cfg_ready) begin
      min_gap  <= cfg_data;
      gap_slot <= cfg_slot;
    end
  end

  // Recurrence: a board gives max(prev, best[i-gap-1] + revenue); the earlier
  // term is zero within the first min_gap+1 miles of a road.
  assign use_earlier = (miles_seen > {1'b0, min_gap});
  assign earlier     = use_earlier ? cell_val[0] : '0;
  assign take        = spsmr_pkg::sat_add(earlier,
                         {{(spsmr_pkg::TOTAL_W-spsmr_pkg::REVENUE_W){1'b0}},
                          board_revenue});
  assign best_next   = (board_here && (take > prev_best)) ? take : prev_best;

  // Road state: advance per mile, drop back to zero after the last mile.
  always_ff @(posedge clk) begin
    if (rst) begin
      miles_seen <= '0;
      prev_best  <= '0;
    end else if (in_accept) begin
      if (last_mile) begin
        miles_seen <= '0;
        prev_best  <= '0;
      end else begin
        prev_best <= best_next;
        if (miles_seen != spsmr_pkg::MILES_MAX) begin
          miles_seen <= miles_seen + 1'b1;
        end
      end
    end
  end

  // History chain: shift toward cell 0 on every accepted mile.
  assign cell_ctl.advance = in_accept;
  assign cell_ctl.slot    = gap_slot;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == NUM_CELLS - 1) begin : g_end
      spsmr_cell #(.CELL_INDEX(k)) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .fresh    (best_next),
        .neighbor (best_next),
        .value    (cell_val[k])
      );
    end else begin : g_mid
      spsmr_cell #(.CELL_INDEX(k)) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .fresh    (best_next),
        .neighbor (cell_val[k+1]),
        .value    (cell_val[k])
      );
    end
  end

  // Result buffer.
  assign res_in.best_total   = best_next;
  assign res_in.final_answer = last_mile;

  spsmr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (res_in),
    .full      (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (res_out)
  );

  assign best_total   = res_out.best_total;
  assign final_answer = res_out.final_answer;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_holding: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted mile produced no result");

  a_best_not_below_prev: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (best_next >= prev_best))
    else $error("running best decreased");

  a_last_mile_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_mile) |=> (miles_seen == '0 && prev_best == '0))
    else $error("road state not cleared after last mile");

  a_slot_in_chain: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> (gap_slot < spsmr_pkg::GAP_W'(NUM_CELLS - 1) ||
                   gap_slot == spsmr_pkg::GAP_W'(NUM_CELLS - 1)))
    else $error("insert slot beyond end of chain");

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for spaced_selection_max_revenue_top: drives roads of
// miles with random boards and revenues, predicts every running best total
// and compares each output beat against it, across several min_gap settings.
// ----------------------------------------------------------------------------

// Predicts the running best total of a road and holds the totals still owed.
class best_total_board;
  logic [spsmr_pkg::TOTAL_W-1:0] totals_by_mile [256];
  logic [7:0]                    ring_slot;
  logic [spsmr_pkg::TOTAL_W-1:0] prior_best;
  logic [spsmr_pkg::MILES_W-1:0] mile_count;
  logic [spsmr_pkg::GAP_W-1:0]   gap;
  spsmr_pkg::result_t            expected_totals[$];
  int                            errors;
  int                            checked;

  function new();
    foreach (totals_by_mile[i]) totals_by_mile[i] = '0;
    restart_road();
    gap     = spsmr_pkg::GAP_W'(spsmr_pkg::GAP_RESET);
    errors  = 0;
    checked = 0;
  endfunction

  function void restart_road();
    ring_slot  = '0;
    prior_best = '0;
    mile_count = '0;
  endfunction

  function void set_gap(logic [spsmr_pkg::GAP_W-1:0] g);
    gap = g;
  endfunction

  function int pending();
    return expected_totals.size();
  endfunction

  // Advance the road by one accepted mile and queue its total.
  function void note_mile(logic here, logic [spsmr_pkg::REVENUE_W-1:0] revenue,
                          logic last);
    logic [spsmr_pkg::TOTAL_W-1:0] best;
    logic [spsmr_pkg::TOTAL_W-1:0] earlier;
    logic [spsmr_pkg::TOTAL_W:0]   take;
    logic [7:0]                    back_slot;
    spsmr_pkg::result_t            r;
    best = prior_best;
    if (here) begin
      earlier = '0;
      if (mile_count > {1'b0, gap}) begin
        back_slot = ring_slot - (gap + 8'd1);
        earlier   = totals_by_mile[back_slot];
      end
      take = {1'b0, earlier} + {{(spsmr_pkg::TOTAL_W-spsmr_pkg::REVENUE_W+1){1'b0}}, revenue};
      if (take[spsmr_pkg::TOTAL_W]) take[spsmr_pkg::TOTAL_W-1:0] = '1;
      if (take[spsmr_pkg::TOTAL_W-1:0] > best) best = take[spsmr_pkg::TOTAL_W-1:0];
    end
    totals_by_mile[ring_slot] = best;
    ring_slot  = ring_slot + 8'd1;
    prior_best = best;
    if (mile_count != spsmr_pkg::MILES_MAX) mile_count = mile_count + 1'b1;
    r.best_total   = best;
    r.final_answer = last;
    expected_totals.push_back(r);
    if (last) restart_road();
  endfunction

  // Compare one output beat with the oldest owed total.
  function void check_total(logic [spsmr_pkg::TOTAL_W-1:0] best, logic fin);
    spsmr_pkg::result_t r;
    if (expected_totals.size() == 0) begin
      $display("%0t: unexpected result beat best_total=%0d final_answer=%0b",
               $time, best, fin);
      errors++;
      return;
    end
    r = expected_totals.pop_front();
    checked++;
    if (best !== r.best_total) begin
      $display("%0t: best_total expected %0d actual %0d", $time, r.best_total, best);
      errors++;
    end
    if (fin !== r.final_answer) begin
      $display("%0t: final_answer expected %0b actual %0b", $time, r.final_answer, fin);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no beat on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_MILES   = 1000;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [spsmr_pkg::GAP_W-1:0]     cfg_data      = '0;
  logic                            in_valid      = 1'b0;
  logic                            in_stall;
  logic                            board_here    = 1'b0;
  logic [spsmr_pkg::REVENUE_W-1:0] board_revenue = '0;
  logic                            last_mile     = 1'b0;
  logic                            out_valid;
  logic                            out_stall     = 1'b0;
  logic [spsmr_pkg::TOTAL_W-1:0]   best_total;
  logic                            final_answer;

  best_total_board board = new();

  // Sender burst shaping: miles left in the current burst, and the longest
  // gap allowed between bursts.
  int burst_left   = 0;
  int max_idle     = 12;
  int miles_sent   = 0;
  int roads_sent   = 0;
  int gap_settings = 0;
  int idle_cycles  = 0;

  spaced_selection_max_revenue_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .board_here   (board_here),
    .board_revenue(board_revenue),
    .last_mile    (last_mile),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .best_total   (best_total),
    .final_answer (final_answer)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure: switch between stall modes at random times so
  // stalls land on every phase, including stretches with none.
  int stall_mode = 0;
  int mode_left  = 0;
  int run_left   = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    stall_tick++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 25);
      2: out_stall <= ($urandom_range(0, 99) < 70);
      3: out_stall <= ((stall_tick % 7) < 3);
      default: begin
        // long runs of stall and release
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left  = $urandom_range(1, 20);
        end else begin
          run_left--;
        end
      end
    endcase
  end

  // Check every result beat taken at this edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_total(best_total, final_answer);
    end
  end

  // Watchdog: count cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results still owed",
                 $time, WATCHDOG_LIMIT, board.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Present one mile and hold it until the block takes it. Between bursts
  // drop valid for a random gap so idling falls on every phase.
  task automatic send_mile(logic here, logic [spsmr_pkg::REVENUE_W-1:0] revenue,
                           logic last);
    int idle_len;
    if (burst_left == 0) begin
      idle_len = (max_idle == 0) ? 0 : $urandom_range(0, max_idle);
      if (idle_len > 0) begin
        in_valid <= 1'b0;
        repeat (idle_len) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid      <= 1'b1;
    board_here    <= here;
    board_revenue <= revenue;
    last_mile     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_mile(here, revenue, last);
    miles_sent++;
    if (last) roads_sent++;
  endtask

  // Drop valid and wait until every owed total has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_gap(logic [spsmr_pkg::GAP_W-1:0] g);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_gap(g);
    gap_settings++;
  endtask

  // One whole road with random boards; the revenue style picks the spread.
  task automatic send_road(int miles, int density, int style);
    logic [spsmr_pkg::REVENUE_W-1:0] revenue;
    logic                            here;
    for (int i = 0; i < miles; i++) begin
      here = ($urandom_range(0, 99) < density);
      case (style)
        0:       revenue = spsmr_pkg::REVENUE_W'($urandom());
        1:       revenue = spsmr_pkg::REVENUE_W'($urandom_range(0, 15));
        2:       revenue = spsmr_pkg::REVENUE_W'(16'hFFFF - $urandom_range(0, 3));
        default: revenue = spsmr_pkg::REVENUE_W'(($urandom_range(0, 1) == 1) ?
                                                  32'hFFFF : $urandom());
      endcase
      send_mile(here, revenue, i == miles - 1);
    end
  endtask

  initial begin
    int g;
    int road_len;
    int pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset gap of 5. Absent boards carry a revenue that must be
    // ignored; mile 7 is the first to reach back to mile 1.
    send_mile(1'b1, 16'hFFFF, 1'b0);
    send_mile(1'b0, 16'h1234, 1'b0);
    send_mile(1'b1, 16'h0000, 1'b0);
    send_mile(1'b1, 16'h8000, 1'b0);
    send_mile(1'b0, 16'hFFFF, 1'b0);
    send_mile(1'b0, 16'h0000, 1'b0);
    send_mile(1'b1, 16'hFFFF, 1'b0);
    send_mile(1'b1, 16'h0001, 1'b1);
    // Single-mile roads, with and without a board.
    send_mile(1'b1, 16'h00FF, 1'b1);
    send_mile(1'b0, 16'hFFFF, 1'b1);
    drain();

    // Gap 0: adjacent boards may both be taken.
    write_gap(8'd0);
    send_mile(1'b1, 16'hFFFF, 1'b0);
    send_mile(1'b1, 16'hFFFF, 1'b0);
    send_mile(1'b0, 16'h5555, 1'b0);
    send_mile(1'b1, 16'h0001, 1'b0);
    send_mile(1'b1, 16'hFFFF, 1'b1);
    drain();

    // Largest gap: every board in a short road competes with the others.
    write_gap(8'd255);
    send_mile(1'b1, 16'hFFFF, 1'b0);
    send_mile(1'b1, 16'h0001, 1'b0);
    send_mile(1'b0, 16'h0000, 1'b1);
    drain();

    // Random phases: a new gap, then a few whole roads, mostly long enough
    // to reach back into the history.
    while (miles_sent < RANDOM_MILES) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       g = 0;
        1:       g = 1;
        2:       g = 255;
        3:       g = 254;
        4:       g = $urandom_range(0, 255);
        default: g = $urandom_range(0, 12);
      endcase
      write_gap(g[7:0]);
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 3)       road_len = $urandom_range(1, 3);
        else if (pick < 6)  road_len = $urandom_range(1, g + 1);
        else                road_len = g + 1 + $urandom_range(0, 30);
        send_road(road_len, $urandom_range(10, 100), $urandom_range(0, 3));
      end
      drain();
    end

    // Long road at the largest gap: the mile count saturates and the
    // history read lands on the slot about to be overwritten.
    write_gap(8'd255);
    send_road(600, 60, 0);
    drain();

    // Back to the reset value of the register.
    write_gap(spsmr_pkg::GAP_W'(spsmr_pkg::GAP_RESET));
    send_road(40, 70, 3);
    drain();
    repeat (4) @(posedge clk);

    if (board.pending() != 0) begin
      $display("%0t: %0d expected totals never arrived", $time, board.pending());
      board.errors++;
    end
    $display("Covered %0d miles in %0d roads over %0d gap settings; %0d totals checked.",
             miles_sent, roads_sent, gap_settings, board.checked);
    $display("Gaps from 0 to 255, a road past the mile-count limit, bursty input and "
             , "receiver stalls; mismatch count: %0d.", board.errors);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/spsmr_pkg.sv
hw/rtl/spsmr_cell.sv
hw/rtl/spsmr_outbuf.sv
hw/rtl/spsmr_pkg_unused_guard.sv
hw/rtl/spaced_selection_max_revenue_top.sv
tb/tb.sv
